// ===== rtl/core/sos_pkg.sv =====
package sos_pkg;

    localparam int MaxStates   = 4;
    localparam int MaxMeasures = 2;
    localparam int MaxControls = 2;

    localparam logic [1:0] CmdStep  = 2'd0;
    localparam logic [1:0] CmdCoeff = 2'd1;
    localparam logic [1:0] CmdEst   = 2'd2;

    localparam logic [1:0] SelA = 2'd0;
    localparam logic [1:0] SelB = 2'd1;
    localparam logic [1:0] SelC = 2'd2;
    localparam logic [1:0] SelL = 2'd3;

    localparam logic [1:0] RegStates   = 2'd0;
    localparam logic [1:0] RegMeasures = 2'd1;
    localparam logic [1:0] RegInputs   = 2'd2;
    localparam logic [1:0] RegPeriod   = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         matrix_select;
        logic [1:0]         row_index;
        logic [1:0]         col_index;
        logic signed [31:0] write_value;
        logic signed [31:0] control_0;
        logic signed [31:0] control_1;
        logic signed [31:0] measure_0;
        logic signed [31:0] measure_1;
        logic               measure_valid;
    } t_in;

    typedef struct packed {
        logic [1:0]         element_index;
        logic signed [31:0] estimate_value;
        logic signed [31:0] predicted_measure;
        logic               last;
    } t_out;

    typedef struct packed {
        logic               start;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               use_term;
    } t_mac_op;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > 52'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -52'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [51:0] qround(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p + 64'sd32768;
        return 52'(q >>> 16);
    endfunction

endpackage

// ===== rtl/core/state_observer_step.sv =====
// One observer step (command 0) runs its phases after its transaction is taken
// and then gives one result per state element in use, one a cycle while the
// result side is ready; coefficient and estimate writes are stored when their
// transaction is taken. Four multiply-accumulate lanes, one per state row, run
// four phases in order: predicted output (up to four terms), system plus input
// terms (up to six terms), period scaling (one term) and innovation gain with
// the merge into the estimate (up to two terms); each phase waits out the lane
// product and accumulator registers. Items are taken one at a time: a new
// transaction is taken the cycle after the last result of a step is accepted.
module state_observer_step
    import sos_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_YH, S_AX, S_TS, S_LIN, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]  r_n;
    logic [1:0]  r_m, r_p;
    logic [30:0] r_ts;
    logic signed [31:0] r_a [MaxStates*MaxStates];
    logic signed [31:0] r_b [MaxStates*MaxControls];
    logic signed [31:0] r_c [MaxMeasures*MaxStates];
    logic signed [31:0] r_l [MaxStates*MaxMeasures];
    logic signed [31:0] r_x [MaxStates];
    logic signed [31:0] r_yh [MaxStates];
    logic signed [31:0] r_innov [MaxMeasures];
    logic signed [31:0] r_f [MaxStates];
    logic signed [51:0] r_t [MaxStates];
    logic signed [31:0] r_xn [MaxStates];
    logic signed [31:0] r_u [MaxControls];
    logic signed [31:0] r_y [MaxMeasures];
    logic [2:0] r_k;
    logic [1:0] r_oi;
    logic [2:0] n_eff;
    logic [1:0] m_eff, p_eff;
    t_mac_op lane_op [MaxStates];
    logic signed [51:0] lane_acc [MaxStates];

    assign n_eff = (r_n == 3'd0) ? 3'd1 : (r_n > 3'd4) ? 3'd4 : r_n;
    assign m_eff = (r_m == 2'd0) ? 2'd1 : (r_m > 2'd2) ? 2'd2 : r_m;
    assign p_eff = (r_p == 2'd0) ? 2'd1 : (r_p > 2'd2) ? 2'd2 : r_p;

    // terms per phase: YH n, AX n+p (k up to 7), TS 1, LIN m; then lane product and accumulator registers
    always_comb begin
        for (int i = 0; i < MaxStates; i++) begin
            lane_op[i] = '{start: (r_k == 3'd0), a: 32'sd0, b: 32'sd0, use_term: 1'b0};
            case (r_state)
                S_YH: begin
                    if (i < MaxMeasures && r_k < {1'b0, n_eff[1:0]} + 3'(n_eff[2] ? 4 : 0)
                        && r_k < 3'd4) begin
                        lane_op[i].a = r_c[i*MaxStates + 32'(r_k[1:0])];
                        lane_op[i].b = r_x[r_k[1:0]];
                        lane_op[i].use_term = 1'b1;
                    end
                end
                S_AX: begin
                    if (r_k < n_eff) begin
                        lane_op[i].a = r_a[i*MaxStates + 32'(r_k[1:0])];
                        lane_op[i].b = r_x[r_k[1:0]];
                        lane_op[i].use_term = 1'b1;
                    end else if (r_k < n_eff + 3'(p_eff)) begin
                        lane_op[i].a = r_b[i*MaxControls + 32'(1'(r_k - n_eff))];
                        lane_op[i].b = r_u[1'(r_k - n_eff)];
                        lane_op[i].use_term = 1'b1;
                    end
                end
                S_TS: begin
                    if (r_k == 3'd0) begin
                        lane_op[i].a = {1'b0, r_ts};
                        lane_op[i].b = r_f[i];
                        lane_op[i].use_term = 1'b1;
                    end
                end
                S_LIN: begin
                    if (r_k < 3'(m_eff)) begin
                        lane_op[i].a = r_l[i*MaxMeasures + 32'(r_k[0])];
                        lane_op[i].b = r_innov[r_k[0]];
                        lane_op[i].use_term = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < MaxStates; g++) begin : g_lane
        sos_lane u_lane (.i_clk(i_clk), .i_op(lane_op[g]), .o_acc(lane_acc[g]));
    end

    logic phase_done;
    always_comb begin
        case (r_state)
            S_YH:  phase_done = (r_k == 3'd5);
            S_AX:  phase_done = (r_k == 3'd7);
            S_TS:  phase_done = (r_k == 3'd2);
            S_LIN: phase_done = (r_k == 3'd3);
            default: phase_done = 1'b0;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == S_OUT);
    assign o_data.element_index     = r_oi;
    assign o_data.estimate_value    = r_xn[r_oi];
    assign o_data.predicted_measure = (3'(r_oi) < 3'(m_eff)) ? r_yh[r_oi] : 32'sd0;
    assign o_data.last              = (3'(r_oi) == n_eff - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= 3'd4; r_m <= 2'd2; r_p <= 2'd2; r_ts <= 31'd65536;
            r_k <= 3'd0; r_oi <= 2'd0;
            for (int r = 0; r < MaxStates; r++)
                for (int c = 0; c < MaxStates; c++)
                    r_a[r*MaxStates + c] <= (r == c) ? 32'sd65536 : 32'sd0;
            for (int i = 0; i < MaxStates*MaxControls; i++) r_b[i] <= 32'sd0;
            for (int i = 0; i < MaxMeasures*MaxStates; i++) r_c[i] <= 32'sd0;
            for (int i = 0; i < MaxStates*MaxMeasures; i++) r_l[i] <= 32'sd0;
            for (int i = 0; i < MaxStates; i++) r_x[i] <= 32'sd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegStates:   r_n  <= i_cfg_data[2:0];
                    RegMeasures: r_m  <= i_cfg_data[1:0];
                    RegInputs:   r_p  <= i_cfg_data[1:0];
                    RegPeriod:   r_ts <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_k <= 3'd0;
                    if (i_valid) begin
                        case (i_data.command)
                            CmdCoeff: begin
                                case (i_data.matrix_select)
                                    SelA: r_a[{i_data.row_index, i_data.col_index}] <=
                                        i_data.write_value;
                                    SelB: if (!i_data.col_index[1])
                                        r_b[{i_data.row_index, i_data.col_index[0]}] <=
                                            i_data.write_value;
                                    SelC: if (!i_data.row_index[1])
                                        r_c[{i_data.row_index[0], i_data.col_index}] <=
                                            i_data.write_value;
                                    SelL: if (!i_data.col_index[1])
                                        r_l[{i_data.row_index, i_data.col_index[0]}] <=
                                            i_data.write_value;
                                    default: ;
                                endcase
                            end
                            CmdEst: r_x[i_data.row_index] <= i_data.write_value;
                            CmdStep: begin
                                r_u[0] <= i_data.control_0;
                                r_u[1] <= i_data.control_1;
                                r_y[0] <= i_data.measure_valid ? i_data.measure_0 : 32'sd0;
                                r_y[1] <= i_data.measure_valid ? i_data.measure_1 : 32'sd0;
                                r_state <= S_YH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_YH, S_AX, S_TS, S_LIN: begin
                    r_k <= phase_done ? 3'd0 : r_k + 3'd1;
                    if (phase_done) begin
                        case (r_state)
                            S_YH: begin
                                for (int i = 0; i < MaxMeasures; i++) begin
                                    r_yh[i] <= sat32(lane_acc[i]);
                                    r_innov[i] <= sat32(52'(r_y[i]) - 52'(sat32(lane_acc[i])));
                                end
                                for (int i = MaxMeasures; i < MaxStates; i++)
                                    r_yh[i] <= 32'sd0;
                                r_state <= S_AX;
                            end
                            S_AX: begin
                                for (int i = 0; i < MaxStates; i++)
                                    r_f[i] <= sat32(lane_acc[i]);
                                r_state <= S_TS;
                            end
                            S_TS: begin
                                for (int i = 0; i < MaxStates; i++) r_t[i] <= lane_acc[i];
                                r_state <= S_LIN;
                            end
                            default: begin
                                for (int i = 0; i < MaxStates; i++) begin
                                    if (3'(i) < n_eff) begin
                                        r_xn[i] <= sat32(52'(r_x[i]) + r_t[i] + lane_acc[i]);
                                        r_x[i]  <= sat32(52'(r_x[i]) + r_t[i] + lane_acc[i]);
                                    end
                                end
                                r_oi <= 2'd0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (3'(r_oi) == n_eff - 3'd1) r_state <= S_IDLE;
                        r_oi <= r_oi + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/sos_lane.sv =====
module sos_lane
    import sos_pkg::*;
(
    input  logic               i_clk,
    input  t_mac_op            i_op,
    output logic signed [51:0] o_acc
);

    logic signed [63:0] r_prod;
    logic               r_use;
    logic               r_start;
    logic signed [51:0] r_acc;

    always_ff @(posedge i_clk) begin
        r_prod  <= i_op.a * i_op.b;
        r_use   <= i_op.use_term;
        r_start <= i_op.start;
        if (r_start) begin
            r_acc <= r_use ? qround(r_prod) : 52'sd0;
        end else if (r_use) begin
            r_acc <= r_acc + qround(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
